### hw/rtl/bfra_pkg.sv
// shared constants and codes for the best-fit region allocator
`timescale 1ns / 1ps

package bfra_pkg;

  localparam int MAX_RECORDS_DEF = 64;
  localparam int OFFSET_BITS_DEF = 16;

  localparam int SIZE_W = 16;
  localparam int ADDR_W = 32;
  localparam int CFG_AW = 3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // register index (bit 2 of the byte address)
  localparam logic REG_REGION_BYTES = 1'b0;
  localparam logic REG_REGION_BASE  = 1'b1;

endpackage

### hw/rtl/bfra_record_mem.sv
// record table memories: offset, length and chain link, one read port each
`timescale 1ns / 1ps

module bfra_record_mem #(
  parameter int MAX_RECORDS = bfra_pkg::MAX_RECORDS_DEF,
  parameter int OFFSET_BITS = bfra_pkg::OFFSET_BITS_DEF,
  parameter int IW          = $clog2(MAX_RECORDS)
) (
  input  logic                      clk,
  input  logic [IW-1:0]             rd_addr,
  output logic [OFFSET_BITS-1:0]    rd_ofs,
  output logic [bfra_pkg::SIZE_W-1:0] rd_len,
  output logic [IW-1:0]             rd_nxt,
  input  logic [IW-1:0]             wr_addr,
  input  logic                      ofs_we,
  input  logic [OFFSET_BITS-1:0]    ofs_wd,
  input  logic                      len_we,
  input  logic [bfra_pkg::SIZE_W-1:0] len_wd,
  input  logic                      nxt_we,
  input  logic [IW-1:0]             nxt_wd
);

  logic [OFFSET_BITS-1:0]      ofs_mem [MAX_RECORDS];
  logic [bfra_pkg::SIZE_W-1:0] len_mem [MAX_RECORDS];
  logic [IW-1:0]               nxt_mem [MAX_RECORDS];

  always_ff @(posedge clk) begin
    if (ofs_we) begin
      ofs_mem[wr_addr] <= ofs_wd;
    end
    if (len_we) begin
      len_mem[wr_addr] <= len_wd;
    end
    if (nxt_we) begin
      nxt_mem[wr_addr] <= nxt_wd;
    end
    rd_ofs <= ofs_mem[rd_addr];
    rd_len <= len_mem[rd_addr];
    rd_nxt <= nxt_mem[rd_addr];
  end

endmodule

### hw/rtl/bfra_gap_unit.sv
// shared gap unit: gap = limit - end of previous block, best-fit compare
`timescale 1ns / 1ps

module bfra_gap_unit #(
  parameter int GW = 18
) (
  input  logic signed [GW-1:0]         limit,
  input  logic signed [GW-1:0]         prev_end,
  input  logic [bfra_pkg::SIZE_W-1:0]  size,
  input  logic signed [GW-1:0]         best,
  input  logic                         found,
  output logic signed [GW-1:0]         gap,
  output logic                         take
);

  logic signed [GW-1:0] size_s;
  logic                 fits;

  assign size_s = $signed(GW'(size));
  assign gap    = limit - prev_end;
  assign fits   = (size_s <= gap);
  // equal gaps keep the first (lowest address) one
  assign take   = fits && ((gap < best) || ((gap == best) && !found));

endmodule

### hw/rtl/best_fit_region_allocator_top.sv
// best-fit region allocator: request sequencer, config registers, result register
`timescale 1ns / 1ps

// Best-fit allocator over one region of region_bytes bytes. Each request beat
// (in_tuser = kind, in_tdata = size) gives exactly one result beat
// (out_tuser = status, out_tdata = address). The block takes one request at a
// time and walks its address-ordered record chain one record per cycle through
// the single read port of the record memory, with one gap compare unit shared
// by every step. An allocation walks the whole chain and a free stops at its
// first match; the first allocation and a request on a full table skip the
// walk. The record memory has no reset and needs no clearing pass: only
// records below the record count are ever read.
module best_fit_region_allocator_top #(
  parameter int MAX_RECORDS = bfra_pkg::MAX_RECORDS_DEF,
  parameter int OFFSET_BITS = bfra_pkg::OFFSET_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // request_size
  input  logic [0:0]                  in_tuser,   // req_type
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // block_address
  output logic [1:0]                  out_tuser,  // status
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bfra_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int IW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int EW = ((OFFSET_BITS > bfra_pkg::SIZE_W) ? OFFSET_BITS : bfra_pkg::SIZE_W) + 1;
  localparam int GW = EW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_TAIL, S_INS1, S_INS2, S_DONE
  } state_t;

  state_t state_r;

  logic [15:0] region_bytes_r;
  logic [31:0] region_base_r;

  logic                        type_r;
  logic [bfra_pkg::SIZE_W-1:0] size_r;
  logic [IW-1:0]               k_r;
  logic [IW-1:0]               cur_r;
  logic [EW-1:0]               prev_end_r;
  logic [IW-1:0]               prev_slot_r;
  logic [IW-1:0]               prev_nxt_r;
  logic signed [GW-1:0]        best_r;
  logic                        found_r;
  logic [IW-1:0]               best_slot_r;
  logic [EW-1:0]               best_end_r;
  logic [IW-1:0]               best_nxt_r;
  logic [CW-1:0]               count_r;
  logic [1:0]                  res_st_r;
  logic [31:0]                 res_addr_r;
  logic                        out_valid_r;
  logic [1:0]                  out_st_r;
  logic [31:0]                 out_addr_r;

  // memory ports
  logic [IW-1:0]               rd_addr;
  logic [OFFSET_BITS-1:0]      rd_ofs;
  logic [bfra_pkg::SIZE_W-1:0] rd_len;
  logic [IW-1:0]               rd_nxt;
  logic [IW-1:0]               wr_addr;
  logic                        ofs_we, len_we, nxt_we;
  logic [OFFSET_BITS-1:0]      ofs_wd;
  logic [bfra_pkg::SIZE_W-1:0] len_wd;
  logic [IW-1:0]               nxt_wd;

  // gap unit
  logic signed [GW-1:0] gu_limit;
  logic signed [GW-1:0] gu_gap;
  logic                 gu_take;

  logic          in_fire;
  logic          cfg_wr;
  logic          first_fits;
  logic          last_rec;
  logic          len_match;
  logic [EW-1:0] cur_end;
  logic [IW-1:0] fresh;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == bfra_pkg::REG_REGION_BASE) ? region_base_r
                                                                   : 32'(region_bytes_r);

  assign first_fits = (in_tdata <= region_bytes_r);
  assign last_rec   = ((CW'(k_r) + CW'(1)) == count_r);
  assign len_match  = (rd_len == size_r);
  assign cur_end    = EW'(rd_ofs) + EW'(rd_len);
  assign fresh      = count_r[IW-1:0];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_st_r;

  // follow the chain: next read address comes straight from the link just read
  assign rd_addr  = (state_r == S_WALK) ? rd_nxt : '0;
  assign gu_limit = (state_r == S_TAIL) ? $signed(GW'(region_bytes_r)) : $signed(GW'(rd_ofs));

  always_comb begin
    wr_addr = '0;
    ofs_we  = 1'b0;
    len_we  = 1'b0;
    nxt_we  = 1'b0;
    ofs_wd  = '0;
    len_wd  = '0;
    nxt_wd  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_tuser[0] == bfra_pkg::REQ_ALLOC) && (count_r == '0)
            && first_fits) begin
          ofs_we = 1'b1;
          len_we = 1'b1;
          nxt_we = 1'b1;
          len_wd = in_tdata;
        end
      end
      S_WALK: begin
        if ((type_r == bfra_pkg::REQ_FREE) && len_match) begin
          wr_addr = cur_r;
          len_we  = 1'b1;
        end
      end
      S_INS1: begin
        wr_addr = fresh;
        ofs_we  = found_r;
        len_we  = found_r;
        nxt_we  = found_r;
        ofs_wd  = best_end_r[OFFSET_BITS-1:0];
        len_wd  = size_r;
        nxt_wd  = best_nxt_r;
      end
      S_INS2: begin
        wr_addr = best_slot_r;
        nxt_we  = 1'b1;
        nxt_wd  = fresh;
      end
      default: begin
      end
    endcase
  end

  bfra_record_mem #(
    .MAX_RECORDS (MAX_RECORDS),
    .OFFSET_BITS (OFFSET_BITS),
    .IW          (IW)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_ofs  (rd_ofs),
    .rd_len  (rd_len),
    .rd_nxt  (rd_nxt),
    .wr_addr (wr_addr),
    .ofs_we  (ofs_we),
    .ofs_wd  (ofs_wd),
    .len_we  (len_we),
    .len_wd  (len_wd),
    .nxt_we  (nxt_we),
    .nxt_wd  (nxt_wd)
  );

  bfra_gap_unit #(
    .GW (GW)
  ) u_gap (
    .limit    (gu_limit),
    .prev_end ($signed(GW'(prev_end_r))),
    .size     (size_r),
    .best     (best_r),
    .found    (found_r),
    .gap      (gu_gap),
    .take     (gu_take)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      region_bytes_r <= '0;
      region_base_r  <= '0;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
      found_r        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[2] == bfra_pkg::REG_REGION_BYTES) begin
          region_bytes_r <= cfg_pwdata[15:0];
        end else begin
          region_base_r <= cfg_pwdata;
        end
      end

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            type_r     <= in_tuser[0];
            size_r     <= in_tdata;
            k_r        <= '0;
            cur_r      <= '0;
            best_r     <= $signed(GW'(region_bytes_r));
            found_r    <= 1'b0;
            res_addr_r <= '0;
            state_r    <= S_WALK;
            if (in_tuser[0] == bfra_pkg::REQ_ALLOC) begin
              if (count_r == '0) begin
                state_r <= S_DONE;
                if (first_fits) begin
                  count_r    <= CW'(1);
                  res_st_r   <= bfra_pkg::ST_OK;
                  res_addr_r <= region_base_r;
                end else begin
                  res_st_r <= bfra_pkg::ST_NOSPACE;
                end
              end else if (count_r == CW'(MAX_RECORDS)) begin
                res_st_r <= bfra_pkg::ST_FULL;
                state_r  <= S_DONE;
              end
            end else if (count_r == '0) begin
              res_st_r <= bfra_pkg::ST_NOMATCH;
              state_r  <= S_DONE;
            end
          end
        end
        S_WALK: begin
          if (type_r == bfra_pkg::REQ_FREE) begin
            if (len_match) begin
              res_st_r <= bfra_pkg::ST_OK;
              state_r  <= S_DONE;
            end else if (last_rec) begin
              res_st_r <= bfra_pkg::ST_NOMATCH;
              state_r  <= S_DONE;
            end else begin
              k_r   <= k_r + IW'(1);
              cur_r <= rd_nxt;
            end
          end else begin
            // gap of the previous record closes at this record's offset
            if ((k_r != '0) && gu_take) begin
              best_r      <= gu_gap;
              found_r     <= 1'b1;
              best_slot_r <= prev_slot_r;
              best_end_r  <= prev_end_r;
              best_nxt_r  <= prev_nxt_r;
            end
            prev_end_r  <= cur_end;
            prev_slot_r <= cur_r;
            prev_nxt_r  <= rd_nxt;
            if (last_rec) begin
              state_r <= S_TAIL;
            end else begin
              k_r   <= k_r + IW'(1);
              cur_r <= rd_nxt;
            end
          end
        end
        S_TAIL: begin
          if (gu_take) begin
            best_r      <= gu_gap;
            found_r     <= 1'b1;
            best_slot_r <= prev_slot_r;
            best_end_r  <= prev_end_r;
            best_nxt_r  <= prev_nxt_r;
          end
          state_r <= S_INS1;
        end
        S_INS1: begin
          if (found_r) begin
            state_r <= S_INS2;
          end else begin
            res_st_r <= bfra_pkg::ST_NOSPACE;
            state_r  <= S_DONE;
          end
        end
        S_INS2: begin
          count_r    <= count_r + CW'(1);
          res_st_r   <= bfra_pkg::ST_OK;
          res_addr_r <= region_base_r + 32'(best_end_r[OFFSET_BITS-1:0]);
          state_r    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_st_r    <= res_st_r;
            out_addr_r  <= res_addr_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_RECORDS))
    else $error("record count above table size");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |-> (count_r == $past(count_r) + CW'(1)))
    else $error("record count moved by other than one");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside the done state");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (count_r != '0))
    else $error("chain walk on an empty table");

endmodule
